// ===== rtl/mpsm_pkg.sv =====
// Package for the multi-pattern string matcher.
// Sizes, derived widths and command codes; no dependencies.
`default_nettype none
package mpsm_pkg;

    localparam int MAX_STATES      = 256;
    localparam int MAX_PATTERNS    = 64;
    localparam int MAX_PATTERN_LEN = 32;
    localparam int RESULT_LIMIT    = 32;

    localparam int NODE_W   = $clog2(MAX_STATES);
    localparam int COUNT_W  = NODE_W + 1;
    localparam int GOTO_AW  = NODE_W + 8;
    localparam int PAT_W    = $clog2(MAX_PATTERNS + 1);
    localparam int DEPTH_W  = $clog2(MAX_PATTERN_LEN + 1);
    localparam int RESN_W   = $clog2(RESULT_LIMIT);
    localparam int ID_W     = 6;
    localparam int POS_W    = 32;

    typedef enum logic [1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_BUILD = 2'd1,
        FUNC_SCAN  = 2'd2,
        FUNC_CLEAR = 2'd3
    } func_t;

endpackage
`default_nettype wire

// ===== rtl/mpsm_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module mpsm_ram #(
    parameter int AW = 8,
    parameter int DW = 8
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);
    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/multi_pattern_string_matcher_core.sv =====
// Top level of the multi-pattern string matcher (Aho-Corasick).
// Depends on mpsm_pkg and mpsm_ram.
`default_nettype none
// Commands are taken when start is high and busy is low. Patterns are added one byte
// at a time, a build command computes failure and output links breadth first, and each
// scanned text byte reports every pattern ending there, up to 32, deepest first, one
// result per cycle on result_valid, the final one marked by last_result. The receiver
// cannot stall: each result is on the ports for exactly one cycle. All tables live in
// synchronous RAMs with registered reads, so rate is set by their read latency: an add
// reads the goto table and then writes, a scan follows failure links and then walks
// the output chain, and a build visits every symbol slot of each node, walks failure
// links for each child, and fetches each node from the queue. After reset and after a
// clear command the goto table is swept to empty, one entry per cycle, over all 65536
// entries, while busy stays high.
module multi_pattern_string_matcher_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  func,
    input  wire logic [7:0]  symbol,
    input  wire logic        pattern_end,
    input  wire logic        text_start,
    output logic             result_valid,
    output logic [5:0]       pattern_id,
    output logic [31:0]      end_position,
    output logic             overflow,
    output logic             last_result
);
    localparam int NW = mpsm_pkg::NODE_W;
    localparam int CW = mpsm_pkg::COUNT_W;
    localparam int GW = mpsm_pkg::GOTO_AW;
    localparam int PW = mpsm_pkg::PAT_W;
    localparam int DW = mpsm_pkg::DEPTH_W;
    localparam int RW = mpsm_pkg::RESN_W;
    localparam int IW = mpsm_pkg::ID_W;
    localparam int XW = mpsm_pkg::POS_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ADD, S_SCAN_GO, S_SCAN_OUT0, S_CHAIN,
        S_B_NODE, S_B_FU, S_B_SYM, S_B_CHILD, S_B_WALK, S_B_OUT, S_B_NEXT, S_B_DEQ
    } state_t;

    // Memory ports
    logic          g_we, f_we, o_we, n_we, q_we;
    logic [GW-1:0] g_waddr, g_raddr;
    logic [NW-1:0] g_wdata, g_rdata;
    logic [NW-1:0] f_waddr, f_wdata, f_raddr, f_rdata;
    logic [NW-1:0] o_waddr, o_wdata, o_raddr, o_rdata;
    logic [NW-1:0] n_waddr, n_raddr;
    logic [PW-1:0] n_wdata, n_rdata;
    logic [NW-1:0] q_waddr, q_wdata, q_raddr, q_rdata;

    mpsm_ram #(.AW(GW), .DW(NW)) u_goto (.clk(clk), .we(g_we), .waddr(g_waddr),
        .wdata(g_wdata), .raddr(g_raddr), .rdata(g_rdata));
    mpsm_ram #(.AW(NW), .DW(NW)) u_fail (.clk(clk), .we(f_we), .waddr(f_waddr),
        .wdata(f_wdata), .raddr(f_raddr), .rdata(f_rdata));
    mpsm_ram #(.AW(NW), .DW(NW)) u_olink (.clk(clk), .we(o_we), .waddr(o_waddr),
        .wdata(o_wdata), .raddr(o_raddr), .rdata(o_rdata));
    mpsm_ram #(.AW(NW), .DW(PW)) u_nout (.clk(clk), .we(n_we), .waddr(n_waddr),
        .wdata(n_wdata), .raddr(n_raddr), .rdata(n_rdata));
    mpsm_ram #(.AW(NW), .DW(NW)) u_queue (.clk(clk), .we(q_we), .waddr(q_waddr),
        .wdata(q_wdata), .raddr(q_raddr), .rdata(q_rdata));

    state_t        state_reg, state_next;
    logic [GW-1:0] clr_reg, clr_next;
    logic [NW-1:0] cursor_reg, cursor_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [CW-1:0] ncount_reg, ncount_next;
    logic [PW-1:0] pcount_reg, pcount_next;
    logic [NW-1:0] scan_reg, scan_next;
    logic [XW-1:0] idx_reg, idx_next;
    logic [XW-1:0] pos_reg, pos_next;
    logic [7:0]    sym_reg, sym_next;
    logic          end_reg, end_next;
    logic [NW-1:0] s_reg, s_next;       // scan walk node, then the node reached
    logic [NW-1:0] u_reg, u_next;
    logic [NW-1:0] fu_reg, fu_next;
    logic [NW-1:0] c_reg, c_next;
    logic [NW-1:0] f_reg, f_next;
    logic [7:0]    a_reg, a_next;
    logic [CW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [RW-1:0] n_reg, n_next;
    logic          rv_reg, rv_next, ov_reg, ov_next, last_reg, last_next;
    logic [IW-1:0] id_reg, id_next;
    logic [XW-1:0] ep_reg, ep_next;

    logic [NW-1:0] new_node, nxt, ol_val, o_first, ff;
    logic          is_last;

    always_comb
    begin
        state_next  = state_reg;   clr_next   = clr_reg;
        cursor_next = cursor_reg;  depth_next = depth_reg;
        ncount_next = ncount_reg;  pcount_next = pcount_reg;
        scan_next   = scan_reg;    idx_next   = idx_reg;
        pos_next    = pos_reg;     sym_next   = sym_reg;
        end_next    = end_reg;     s_next     = s_reg;
        u_next      = u_reg;       fu_next    = fu_reg;
        c_next      = c_reg;       f_next     = f_reg;
        a_next      = a_reg;       head_next  = head_reg;
        tail_next   = tail_reg;    n_next     = n_reg;
        rv_next     = 1'b0;        ov_next    = 1'b0;
        last_next   = 1'b0;        id_next    = id_reg;
        ep_next     = ep_reg;

        g_we = 1'b0; g_waddr = '0; g_wdata = '0; g_raddr = '0;
        f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_raddr = '0;
        o_we = 1'b0; o_waddr = '0; o_wdata = '0; o_raddr = '0;
        n_we = 1'b0; n_waddr = '0; n_wdata = '0; n_raddr = '0;
        q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_raddr = '0;

        new_node = ncount_reg[NW-1:0];
        nxt      = g_rdata;
        ol_val   = '0;
        o_first  = '0;
        ff       = '0;
        is_last  = 1'b0;

        case (state_reg)
            // Sweep the goto table empty; drop node outputs in the low rows.
            S_CLEAR:
            begin
                g_we    = 1'b1;
                g_waddr = clr_reg;
                if (clr_reg[GW-1:NW] == '0)
                begin
                    n_we    = 1'b1;
                    n_waddr = clr_reg[NW-1:0];
                end
                clr_next = clr_reg + 1'b1;
                if (clr_reg == {GW{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    sym_next = symbol;
                    end_next = pattern_end;
                    case (func)
                        mpsm_pkg::FUNC_ADD:
                        begin
                            g_raddr    = {cursor_reg, symbol};
                            state_next = S_ADD;
                        end
                        mpsm_pkg::FUNC_BUILD:
                        begin
                            u_next     = '0;
                            fu_next    = '0;
                            a_next     = '0;
                            head_next  = '0;
                            tail_next  = '0;
                            state_next = S_B_SYM;
                        end
                        mpsm_pkg::FUNC_SCAN:
                        begin
                            s_next = text_start ? '0 : scan_reg;
                            if (text_start)
                            begin
                                idx_next = '0;
                            end
                            g_raddr    = {(text_start ? {NW{1'b0}} : scan_reg), symbol};
                            f_raddr    = text_start ? '0 : scan_reg;
                            state_next = S_SCAN_GO;
                        end
                        default:
                        begin
                            cursor_next = '0;
                            depth_next  = '0;
                            ncount_next = CW'(1);
                            pcount_next = '0;
                            scan_next   = '0;
                            idx_next    = '0;
                            clr_next    = '0;
                            state_next  = S_CLEAR;
                        end
                    endcase
                end
            end

            S_ADD:
            begin
                state_next = S_IDLE;
                if (g_rdata == '0 && (ncount_reg >= CW'(mpsm_pkg::MAX_STATES) ||
                    depth_reg >= DW'(mpsm_pkg::MAX_PATTERN_LEN)))
                begin
                    rv_next = 1'b1; ov_next = 1'b1; last_next = 1'b1;
                    id_next = '0;   ep_next = '0;
                    if (end_reg)
                    begin
                        cursor_next = '0;
                        depth_next  = '0;
                    end
                end
                else
                begin
                    if (g_rdata == '0)
                    begin
                        // Allocate a fresh node with root links and no output.
                        nxt     = new_node;
                        g_we    = 1'b1;
                        g_waddr = {cursor_reg, sym_reg};
                        g_wdata = new_node;
                        f_we    = 1'b1; f_waddr = new_node;
                        o_we    = 1'b1; o_waddr = new_node;
                        n_we    = 1'b1; n_waddr = new_node;
                        ncount_next = ncount_reg + 1'b1;
                    end
                    if (!end_reg)
                    begin
                        cursor_next = nxt;
                        depth_next  = depth_reg + 1'b1;
                    end
                    else
                    begin
                        cursor_next = '0;
                        depth_next  = '0;
                        if (pcount_reg >= PW'(mpsm_pkg::MAX_PATTERNS))
                        begin
                            rv_next = 1'b1; ov_next = 1'b1; last_next = 1'b1;
                            id_next = '0;   ep_next = '0;
                        end
                        else
                        begin
                            n_we        = 1'b1;
                            n_waddr     = nxt;
                            n_wdata     = pcount_reg + 1'b1;
                            pcount_next = pcount_reg + 1'b1;
                        end
                    end
                end
            end

            // Follow failure links until a goto hits or the root is reached.
            S_SCAN_GO:
            begin
                if (s_reg != '0 && g_rdata == '0)
                begin
                    s_next  = f_rdata;
                    g_raddr = {f_rdata, sym_reg};
                    f_raddr = f_rdata;
                end
                else
                begin
                    s_next    = g_rdata;
                    scan_next = g_rdata;
                    pos_next  = idx_reg;
                    if (idx_reg != {XW{1'b1}})
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                    n_raddr    = g_rdata;
                    o_raddr    = g_rdata;
                    state_next = S_SCAN_OUT0;
                end
            end

            S_SCAN_OUT0:
            begin
                n_next  = '0;
                o_first = (n_rdata != '0) ? s_reg : ((s_reg == '0) ? '0 : o_rdata);
                if (o_first == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    n_raddr    = o_first;
                    o_raddr    = o_first;
                    state_next = S_CHAIN;
                end
            end

            // Emit one match per cycle down the output chain.
            S_CHAIN:
            begin
                is_last   = (o_rdata == '0) || (n_reg == {RW{1'b1}});
                rv_next   = 1'b1;
                last_next = is_last;
                id_next   = IW'(n_rdata - 1'b1);
                ep_next   = pos_reg;
                n_next    = n_reg + 1'b1;
                if (is_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    n_raddr = o_rdata;
                    o_raddr = o_rdata;
                end
            end

            S_B_NODE:
            begin
                f_raddr    = u_reg;
                state_next = S_B_FU;
            end

            S_B_FU:
            begin
                fu_next    = f_rdata;
                a_next     = '0;
                state_next = S_B_SYM;
            end

            S_B_SYM:
            begin
                g_raddr    = {u_reg, a_reg};
                state_next = S_B_CHILD;
            end

            S_B_CHILD:
            begin
                if (g_rdata == '0)
                begin
                    if (a_reg == 8'hFF)
                    begin
                        state_next = S_B_NEXT;
                    end
                    else
                    begin
                        a_next     = a_reg + 1'b1;
                        state_next = S_B_SYM;
                    end
                end
                else
                begin
                    c_next     = g_rdata;
                    f_next     = fu_reg;
                    g_raddr    = {fu_reg, a_reg};
                    f_raddr    = fu_reg;
                    state_next = S_B_WALK;
                end
            end

            S_B_WALK:
            begin
                if (f_reg != '0 && g_rdata == '0)
                begin
                    f_next  = f_rdata;
                    g_raddr = {f_rdata, a_reg};
                    f_raddr = f_rdata;
                end
                else
                begin
                    ff         = (g_rdata != '0 && g_rdata != c_reg) ? g_rdata : '0;
                    f_we       = 1'b1;
                    f_waddr    = c_reg;
                    f_wdata    = ff;
                    f_next     = ff;
                    n_raddr    = ff;
                    o_raddr    = ff;
                    state_next = S_B_OUT;
                end
            end

            S_B_OUT:
            begin
                ol_val    = (n_rdata != '0) ? f_reg : ((f_reg == '0) ? '0 : o_rdata);
                o_we      = 1'b1;
                o_waddr   = c_reg;
                o_wdata   = ol_val;
                q_we      = 1'b1;
                q_waddr   = tail_reg[NW-1:0];
                q_wdata   = c_reg;
                tail_next = tail_reg + 1'b1;
                if (a_reg == 8'hFF)
                begin
                    state_next = S_B_NEXT;
                end
                else
                begin
                    a_next     = a_reg + 1'b1;
                    state_next = S_B_SYM;
                end
            end

            S_B_NEXT:
            begin
                if (head_reg != tail_reg)
                begin
                    q_raddr    = head_reg[NW-1:0];
                    head_next  = head_reg + 1'b1;
                    state_next = S_B_DEQ;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_B_DEQ:
            begin
                u_next     = q_rdata;
                state_next = S_B_NODE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            cursor_reg <= '0;
            depth_reg  <= '0;
            ncount_reg <= CW'(1);
            pcount_reg <= '0;
            scan_reg   <= '0;
            idx_reg    <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            n_reg      <= '0;
            rv_reg     <= 1'b0;
            ov_reg     <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            cursor_reg <= cursor_next;
            depth_reg  <= depth_next;
            ncount_reg <= ncount_next;
            pcount_reg <= pcount_next;
            scan_reg   <= scan_next;
            idx_reg    <= idx_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            n_reg      <= n_next;
            rv_reg     <= rv_next;
            ov_reg     <= ov_next;
            last_reg   <= last_next;
        end
    end

    // Payload registers hold without reset.
    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        sym_reg <= sym_next;
        end_reg <= end_next;
        s_reg   <= s_next;
        u_reg   <= u_next;
        fu_reg  <= fu_next;
        c_reg   <= c_next;
        f_reg   <= f_next;
        a_reg   <= a_next;
        id_reg  <= id_next;
        ep_reg  <= ep_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = rv_reg;
    assign pattern_id   = id_reg;
    assign end_position = ep_reg;
    assign overflow     = ov_reg;
    assign last_result  = last_reg;
endmodule
`default_nettype wire

// ===== bench/multi_pattern_string_matcher_core_test.sv =====
// Self-checking bench for multi_pattern_string_matcher_core.
// Depends on mpsm_pkg and the core; it predicts every match and overflow result itself.
`timescale 1ns / 100ps
module multi_pattern_string_matcher_core_test;

    localparam int TIMEOUT_CYCLES = 5000000;
    localparam int TAIL_CYCLES    = 200;

    // One stimulus command, plus the idle time that follows its transfer.
    typedef struct {
        mpsm_pkg::func_t fn;
        logic [7:0]      sym;
        logic            pend;
        logic            tstart;
        int              gap;
        bit              drain;   // hold this command until every match has come back
    } command_t;

    // One result the core should produce.
    typedef struct {
        logic [5:0]  id;
        logic [31:0] pos;
        logic        ovf;
        logic        last;
    } match_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  func = mpsm_pkg::FUNC_CLEAR;
    logic [7:0]  symbol = 8'd0;
    logic        pattern_end = 1'b0;
    logic        text_start = 1'b0;
    logic        result_valid;
    logic [5:0]  pattern_id;
    logic [31:0] end_position;
    logic        overflow;
    logic        last_result;

    command_t cmd_q[$];
    match_t   match_q[$];
    command_t cur_cmd;
    int       gap_left = 0;
    int       fail_count = 0;
    int       cycle_count = 0;

    // Private copy of the trie, links and counters.
    logic [8:0]  trie [0:65535];
    logic [7:0]  fail_to [0:255];
    logic [8:0]  out_to [0:255];
    logic [6:0]  node_id [0:255];
    int unsigned nodes, cursor, depth, npat, scan_at;
    logic [31:0] text_pos;

    multi_pattern_string_matcher_core uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .symbol(symbol), .pattern_end(pattern_end), .text_start(text_start),
        .result_valid(result_valid), .pattern_id(pattern_id),
        .end_position(end_position), .overflow(overflow), .last_result(last_result)
    );

    always #2 clk = ~clk;

    function automatic int unsigned next_node(int unsigned s, int unsigned a);
        if (s >= mpsm_pkg::MAX_STATES)
            return 0;
        return trie[s * 256 + a];
    endfunction

    function automatic void clear_dict();
        for (int i = 0; i < 65536; i++)
            trie[i] = '0;
        for (int i = 0; i < mpsm_pkg::MAX_STATES; i++)
        begin
            fail_to[i] = '0;
            out_to[i]  = '0;
            node_id[i] = '0;
        end
        nodes = 1; cursor = 0; depth = 0; npat = 0; scan_at = 0; text_pos = '0;
    endfunction

    function automatic void add_match(match_t m);
        match_q.insert(match_q.size(), m);
    endfunction

    function automatic void push_overflow();
        match_t m;
        m.id = '0; m.pos = '0; m.ovf = 1'b1; m.last = 1'b1;
        add_match(m);
    endfunction

    function automatic void insert_byte(int unsigned a, logic fin);
        int unsigned n;
        n = next_node(cursor, a);
        if (n == 0)
        begin
            // Drop the byte when the trie or the pattern length is exhausted.
            if (nodes >= mpsm_pkg::MAX_STATES || depth >= mpsm_pkg::MAX_PATTERN_LEN)
            begin
                if (fin)
                begin
                    cursor = 0; depth = 0;
                end
                push_overflow();
                return;
            end
            n = nodes++;
            trie[cursor * 256 + a] = n[8:0];
            fail_to[n] = '0; out_to[n] = '0; node_id[n] = '0;
        end
        cursor = n;
        if (depth < 255)
            depth++;
        if (!fin)
            return;
        cursor = 0; depth = 0;
        if (npat >= mpsm_pkg::MAX_PATTERNS)
        begin
            push_overflow();
            return;
        end
        node_id[n] = 7'(npat + 1);
        npat++;
    endfunction

    function automatic void link_trie();
        int unsigned bfs[$];
        int unsigned u, c, f, t, guard;
        fail_to[0] = '0; out_to[0] = '0;
        for (int a = 0; a < 256; a++)
        begin
            c = next_node(0, a);
            if (c != 0 && bfs.size() < mpsm_pkg::MAX_STATES)
            begin
                fail_to[c] = '0; out_to[c] = '0;
                bfs.insert(bfs.size(), c);
            end
        end
        for (int h = 0; h < bfs.size(); h++)
        begin
            u = bfs[h];
            for (int a = 0; a < 256; a++)
            begin
                c = next_node(u, a);
                if (c == 0)
                    continue;
                f = fail_to[u];
                guard = 0;
                while (f != 0 && next_node(f, a) == 0 && guard++ < mpsm_pkg::MAX_STATES)
                    f = fail_to[f];
                t = next_node(f, a);
                f = (t != 0 && t != c) ? t : 0;
                fail_to[c] = f[7:0];
                out_to[c] = (node_id[f] != 0) ? f[8:0] : out_to[f];
                if (bfs.size() < mpsm_pkg::MAX_STATES)
                    bfs.insert(bfs.size(), c);
            end
        end
    endfunction

    function automatic void scan_byte(int unsigned a, logic restart);
        int unsigned s, o, guard, n;
        logic [31:0] here;
        match_t m;
        if (restart)
        begin
            scan_at = 0; text_pos = '0;
        end
        s = scan_at;
        guard = 0;
        while (s != 0 && next_node(s, a) == 0 && guard++ < mpsm_pkg::MAX_STATES)
            s = fail_to[s];
        s = next_node(s, a);
        scan_at = s;
        here = text_pos;
        if (text_pos != 32'hFFFF_FFFF)
            text_pos++;
        // Walk the output chain deepest first, capped at the result limit.
        o = (node_id[s] != 0) ? s : out_to[s];
        guard = 0; n = 0;
        while (o != 0 && n < mpsm_pkg::RESULT_LIMIT && guard++ < mpsm_pkg::MAX_STATES)
        begin
            m.id = 6'(node_id[o] - 1); m.pos = here; m.ovf = 1'b0; m.last = 1'b0;
            add_match(m);
            n++;
            o = out_to[o];
        end
        if (n > 0)
            match_q[match_q.size() - 1].last = 1'b1;
    endfunction

    function automatic void predict(command_t c);
        case (c.fn)
            mpsm_pkg::FUNC_ADD:   insert_byte(c.sym, c.pend);
            mpsm_pkg::FUNC_BUILD: link_trie();
            mpsm_pkg::FUNC_SCAN:  scan_byte(c.sym, c.tstart);
            default:              clear_dict();
        endcase
    endfunction

    // Mostly short idles, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic void queue_cmd(mpsm_pkg::func_t fn, logic [7:0] sym, logic pend,
                                      logic tstart, bit calm, bit drain = 1'b0);
        command_t c;
        c.fn = fn; c.sym = sym; c.pend = pend; c.tstart = tstart;
        c.gap = calm ? 0 : pick_gap();
        c.drain = drain;
        cmd_q.insert(cmd_q.size(), c);
    endfunction

    function automatic void queue_pattern(string p, bit calm);
        for (int i = 0; i < p.len(); i++)
            queue_cmd(mpsm_pkg::FUNC_ADD, p[i], i == p.len() - 1, $urandom_range(1), calm);
    endfunction

    function automatic void queue_text(string p, logic restart, bit calm);
        for (int i = 0; i < p.len(); i++)
            queue_cmd(mpsm_pkg::FUNC_SCAN, p[i], $urandom_range(1), restart && i == 0,
                      calm);
    endfunction

    // Random byte drawn mostly from a small alphabet so patterns hit often.
    function automatic logic [7:0] pick_sym();
        string alpha;
        alpha = "abc";
        if ($urandom_range(19) == 0)
            return 8'($urandom_range(255));
        return alpha[$urandom_range(2)];
    endfunction

    // Driver: present the next command once the previous one was transferred.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predict(cur_cmd);
                gap_left = cur_cmd.gap;
            end
            if (start && busy)
            begin
                // hold the current command until the core takes it
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (cmd_q.size() > 0 && (!cmd_q[0].drain || match_q.size() == 0))
            begin
                cur_cmd = cmd_q.pop_front();
                func <= cur_cmd.fn;
                symbol <= cur_cmd.sym;
                pattern_end <= cur_cmd.pend;
                text_start <= cur_cmd.tstart;
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: every strobed result must match the oldest expectation.
    always @(posedge clk)
    begin
        match_t m;
        if (rst_n && result_valid)
        begin
            if (match_q.size() == 0)
            begin
                $error("unexpected result id=%0d pos=%0d ovf=%0b", pattern_id,
                       end_position, overflow);
                fail_count++;
            end
            else
            begin
                m = match_q.pop_front();
                if (pattern_id !== m.id)
                begin
                    $error("pattern_id expected %0d got %0d", m.id, pattern_id);
                    fail_count++;
                end
                if (end_position !== m.pos)
                begin
                    $error("end_position expected %0d got %0d", m.pos, end_position);
                    fail_count++;
                end
                if (overflow !== m.ovf)
                begin
                    $error("overflow expected %0b got %0b", m.ovf, overflow);
                    fail_count++;
                end
                if (last_result !== m.last)
                begin
                    $error("last_result expected %0b got %0b", m.last, last_result);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog against a hung core.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        string p;
        int    k;
        bit    calm;
        clear_dict();

        // Directed: extreme bytes, add, scan and build commands, duplicate ids, scan before build.
        queue_pattern("he", 0);
        queue_pattern("she", 0);
        queue_pattern("his", 0);
        queue_pattern("hers", 0);
        queue_pattern("he", 0);
        queue_cmd(mpsm_pkg::FUNC_ADD, 8'h00, 1'b0, 1'b1, 0);
        queue_cmd(mpsm_pkg::FUNC_ADD, 8'hFF, 1'b1, 1'b0, 0);
        queue_text("ushers", 1'b1, 0);
        queue_cmd(mpsm_pkg::FUNC_BUILD, 8'hFF, 1'b1, 1'b1, 0);
        queue_text("ushers", 1'b1, 0);
        queue_cmd(mpsm_pkg::FUNC_SCAN, 8'h00, 1'b0, 1'b0, 0);
        queue_cmd(mpsm_pkg::FUNC_SCAN, 8'hFF, 1'b1, 1'b0, 0, 1'b1);

        // Output chain: a, aa, ... then one pattern past the length limit.
        queue_cmd(mpsm_pkg::FUNC_CLEAR, 8'h00, 1'b0, 1'b0, 1);
        p = "";
        for (int i = 0; i < 8; i++)
        begin
            p = {p, "a"};
            queue_pattern(p, 1);
        end
        p = "";
        for (int i = 0; i <= mpsm_pkg::MAX_PATTERN_LEN; i++)
            p = {p, "a"};
        queue_pattern(p, 0);
        queue_cmd(mpsm_pkg::FUNC_BUILD, 8'h00, 1'b0, 1'b0, 0);
        queue_text("aaaaaaaaaaaa", 1'b1, 0);

        // Pattern table full: duplicates of one byte push the count past the limit.
        for (int i = 0; i < 60; i++)
            queue_pattern("a", 1);
        queue_text("aab", 1'b1, 0);

        // Random rounds: fresh dictionary, a few patterns, usually a link, then text.
        for (int r = 0; r < 3; r++)
        begin
            calm = (r == 1);
            queue_cmd(mpsm_pkg::FUNC_CLEAR, 8'h00, 1'b0, 1'b0, calm, 1'b1);
            k = $urandom_range(8, 4);
            for (int j = 0; j < k; j++)
            begin
                p = "";
                for (int i = $urandom_range(5, 1); i > 0; i--)
                begin
                    p = {p, " "};
                    p.putc(p.len() - 1, pick_sym());
                end
                queue_pattern(p, calm);
            end
            if ($urandom_range(3) != 0)
                queue_cmd(mpsm_pkg::FUNC_BUILD, 8'($urandom_range(255)), 1'b0, 1'b0, calm);
            for (int i = 0; i < 25; i++)
            begin
                // Mostly text; a little noise of stray adds and repeated builds.
                case ($urandom_range(29))
                    0: queue_cmd(mpsm_pkg::FUNC_ADD, pick_sym(), $urandom_range(1), 1'b0,
                                 calm);
                    1: queue_cmd(mpsm_pkg::FUNC_BUILD, pick_sym(), 1'b0, 1'b0, calm);
                    default: queue_cmd(mpsm_pkg::FUNC_SCAN, pick_sym(), $urandom_range(1),
                                       $urandom_range(24) == 0, calm,
                                       $urandom_range(39) == 0);
                endcase
            end
        end
        queue_text("abc", 1'b1, 0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_q.size() > 0 || start)
            @(posedge clk);
        while (match_q.size() > 0 || busy)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && match_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
